/* src/assert_macros.svh */
// Assertion macros used by the checker file of this block.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* src/tsrp_pkg.sv */
// Package for the throttled serial receive port.
// Holds sizes, function and register codes, status constants and the result type.
// No dependencies.
package tsrp_pkg;

  localparam int QUEUE_DEPTH = 256;
  localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
  localparam int PTR_W       = ADDR_W + 1;
  localparam int BURST_W     = 9;
  localparam int WAIT_W      = 17;
  localparam int LIMIT_W     = 8;
  localparam int THR_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [2:0] {
    FN_RX_BYTE   = 3'd0,
    FN_DATA_RD   = 3'd1,
    FN_STATUS_RD = 3'd2,
    FN_DATA_WR   = 3'd3,
    FN_CTRL_WR   = 3'd4,
    FN_TICK      = 3'd5
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BURST_LIMIT = 2'd0,
    REG_THROTTLE_MS = 2'd1
  } cfg_reg_t;

  localparam logic [7:0] EMPTY_READ  = 8'hff;
  localparam logic [7:0] ST_RX_READY = 8'h01;
  localparam logic [7:0] ST_TX_EMPTY = 8'h02;
  localparam logic [7:0] ST_CARRIER  = 8'h04;
  localparam logic [7:0] ST_CLEAR    = 8'h08;

  localparam logic [LIMIT_W-1:0] BURST_LIMIT_RST = 8'd8;
  localparam logic [THR_W-1:0]   THROTTLE_RST    = 16'd10;

  typedef struct packed {
    logic       pop;
    logic [7:0] rd;
    logic       txv;
    logic [7:0] txb;
    logic       drop;
  } result_t;

endpackage

/* src/throttled_serial_receive_port_top.sv */
// Top level of the throttled serial receive port.
// Depends on tsrp_pkg for sizes, codes and the result type.
//
// Usage: each input beat carries func and data_in; each accepted beat gives
// exactly one result beat with read_data, tx_valid, tx_byte and dropped.
// Arriving bytes go into a linear receive buffer held in a memory; data reads
// pop it, subject to a burst limit that arms a throttle wait counted in tick
// beats. Registers burst_limit (index 0) and throttle_ms (index 1) are written
// through the cfg channel, which is always ready.
// Throughput is one beat per cycle while the receiver does not stall: all state updates finish in the accept
// cycle, and the memory read issued then is registered into the first stage.
// A result passes through the registered memory read and the first stage, then
// through the output register.
// A synchronous reset empties the buffer, clears the counters and pipeline,
// and restores the register defaults. When the receiver stalls, the output
// register holds its beat, one more beat waits in the first stage, and only
// then does in_ready fall.
module throttled_serial_receive_port_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [2:0]                     func,
  input  logic [7:0]                     data_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     read_data,
  output logic                           tx_valid,
  output logic [7:0]                     tx_byte,
  output logic                           dropped,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tsrp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tsrp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tsrp_pkg::*;

  logic [7:0]         rx_store [QUEUE_DEPTH];
  logic [7:0]         mem_q;
  logic [LIMIT_W-1:0] burst_limit;
  logic [THR_W-1:0]   throttle_ms;
  logic [PTR_W-1:0]   head_index, head_index_next;
  logic [PTR_W-1:0]   tail_index, tail_index_next;
  logic [PTR_W-1:0]   tail_eff, head_inc;
  logic [BURST_W-1:0] burst_count, burst_count_next;
  logic [WAIT_W-1:0]  wait_ticks, wait_ticks_next;
  logic               avail;
  logic               store_we;
  logic [ADDR_W-1:0]  store_addr;
  result_t            res;
  result_t            s1;
  logic               s1_valid;
  logic               s1_adv;
  logic               in_fire;

  assign cfg_ready = 1'b1;
  assign s1_adv    = !out_valid || out_ready;
  assign in_ready  = !s1_valid || s1_adv;
  assign in_fire   = in_valid && in_ready;
  assign avail     = (head_index != tail_index) && (wait_ticks == '0);
  assign head_inc  = head_index + 1'b1;

  always_comb begin
    head_index_next  = head_index;
    tail_index_next  = tail_index;
    burst_count_next = burst_count;
    wait_ticks_next  = wait_ticks;
    tail_eff         = tail_index;
    store_we         = 1'b0;
    store_addr       = tail_index[ADDR_W-1:0];
    res              = '0;
    case (func)
      FN_RX_BYTE: begin
        if (head_index == tail_index && head_index != '0) begin
          head_index_next = '0;
          tail_eff        = '0;
        end
        if (tail_eff < PTR_W'(QUEUE_DEPTH)) begin
          store_we        = 1'b1;
          store_addr      = tail_eff[ADDR_W-1:0];
          tail_index_next = tail_eff + 1'b1;
        end else begin
          tail_index_next = tail_eff;
          res.drop        = 1'b1;
        end
      end
      FN_DATA_RD: begin
        if (avail) begin
          if (burst_count > {1'b0, burst_limit}) begin
            wait_ticks_next  = {1'b0, throttle_ms} + 1'b1;
            burst_count_next = BURST_W'(1);
          end else if (burst_count != '1) begin
            burst_count_next = burst_count + 1'b1;
          end
          if (head_inc == tail_index) begin
            head_index_next = '0;
            tail_index_next = '0;
          end else begin
            head_index_next = head_inc;
          end
          res.pop = 1'b1;
        end else begin
          res.rd = EMPTY_READ;
        end
      end
      FN_STATUS_RD: begin
        res.rd = ST_TX_EMPTY | ST_CARRIER | ST_CLEAR | (avail ? ST_RX_READY : 8'h00);
      end
      FN_DATA_WR: begin
        res.txv = 1'b1;
        res.txb = data_in;
      end
      FN_TICK: begin
        if (wait_ticks != '0) begin
          wait_ticks_next = wait_ticks - 1'b1;
        end
      end
      FN_CTRL_WR: begin
        res = '0;
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      burst_limit <= BURST_LIMIT_RST;
      throttle_ms <= THROTTLE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BURST_LIMIT: burst_limit <= cfg_data[LIMIT_W-1:0];
        REG_THROTTLE_MS: throttle_ms <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_index  <= '0;
      tail_index  <= '0;
      burst_count <= '0;
      wait_ticks  <= '0;
    end else if (in_fire) begin
      head_index  <= head_index_next;
      tail_index  <= tail_index_next;
      burst_count <= burst_count_next;
      wait_ticks  <= wait_ticks_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && store_we) begin
      rx_store[store_addr] <= data_in;
    end
    if (in_fire) begin
      mem_q <= rx_store[head_index[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1 <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      read_data <= s1.pop ? mem_q : s1.rd;
      tx_valid  <= s1.txv;
      tx_byte   <= s1.txb;
      dropped   <= s1.drop;
    end
  end

endmodule

/* src/tsrp_chk.sv */
// Port-level checker for the throttled serial receive port, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module tsrp_chk (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] read_data,
  input logic       tx_valid,
  input logic [7:0] tx_byte,
  input logic       dropped
);

  // A transmitted byte never comes with read data or a drop.
  `AST_IMP(a_tx_excl, out_valid && tx_valid, read_data == 8'd0 && !dropped)

  // Without a transmit, the transmit byte is zero.
  `AST_IMP(a_tx_zero, out_valid && !tx_valid, tx_byte == 8'd0)

  // A dropped byte gives no read data and no transmit.
  `AST_IMP(a_drop_excl, out_valid && dropped, read_data == 8'd0 && !tx_valid)

  // A stalled result beat stays on the port with its read data unchanged.
  `AST_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(read_data))

endmodule

bind throttled_serial_receive_port_top tsrp_chk u_tsrp_chk (.*);

/* tb/throttled_serial_receive_port_watch.sv */
// Watcher for the throttled serial receive port: follows the input, output and register
// channels, predicts every result beat and compares it with what the block delivers.
// Depends on tsrp_pkg for sizes, function codes, register codes and status bits.
`timescale 1ns / 100ps

module throttled_serial_receive_port_watch (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [2:0]                      func,
  input  logic [7:0]                      data_in,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [7:0]                      read_data,
  input  logic                            tx_valid,
  input  logic [7:0]                      tx_byte,
  input  logic                            dropped,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [tsrp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tsrp_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              failures,
  output int                              pending
);
  import tsrp_pkg::*;

  typedef struct packed {
    logic [7:0] rd;
    logic       txv;
    logic [7:0] txb;
    logic       drop;
  } port_beat_t;

  logic [7:0]         rx_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W-1:0]   wr_ptr;
  logic [BURST_W-1:0] reads_in_burst;
  logic [WAIT_W-1:0]  hold_ticks;
  logic [LIMIT_W-1:0] limit_reg;
  logic [THR_W-1:0]   throttle_reg;
  port_beat_t         owed_results [$];

  initial begin
    failures = 0;
    pending = 0;
  end

  function automatic port_beat_t predict_access(input logic [2:0] fn, input logic [7:0] din);
    port_beat_t r;
    logic       rx_ready;
    r = '0;
    rx_ready = (rd_ptr != wr_ptr) && (hold_ticks == '0);
    case (fn)
      FN_RX_BYTE: begin
        if (rd_ptr == wr_ptr && rd_ptr != '0) begin
          rd_ptr = '0;
          wr_ptr = '0;
        end
        if (wr_ptr < PTR_W'(QUEUE_DEPTH)) begin
          rx_mem[wr_ptr[ADDR_W-1:0]] = din;
          wr_ptr = wr_ptr + 1'b1;
        end else begin
          r.drop = 1'b1;
        end
      end
      FN_DATA_RD: begin
        if (rx_ready) begin
          if (reads_in_burst > BURST_W'(limit_reg)) begin
            hold_ticks = WAIT_W'(throttle_reg) + 1'b1;
            reads_in_burst = '0;
          end
          if (reads_in_burst != '1) reads_in_burst = reads_in_burst + 1'b1;
          r.rd = rx_mem[rd_ptr[ADDR_W-1:0]];
          rd_ptr = rd_ptr + 1'b1;
          if (rd_ptr == wr_ptr) begin
            rd_ptr = '0;
            wr_ptr = '0;
          end
        end else begin
          r.rd = EMPTY_READ;
        end
      end
      FN_STATUS_RD: begin
        r.rd = ST_TX_EMPTY | ST_CARRIER | ST_CLEAR | (rx_ready ? ST_RX_READY : 8'h00);
      end
      FN_DATA_WR: begin
        r.txv = 1'b1;
        r.txb = din;
      end
      FN_TICK: begin
        if (hold_ticks != '0) hold_ticks = hold_ticks - 1'b1;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    port_beat_t want;
    port_beat_t got;
    if (rst) begin
      rd_ptr = '0;
      wr_ptr = '0;
      reads_in_burst = '0;
      hold_ticks = '0;
      limit_reg = BURST_LIMIT_RST;
      throttle_reg = THROTTLE_RST;
      owed_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BURST_LIMIT: limit_reg = cfg_data[LIMIT_W-1:0];
          REG_THROTTLE_MS: throttle_reg = cfg_data[THR_W-1:0];
          default: begin
          end
        endcase
      end
      if (in_valid && in_ready) owed_results.push_back(predict_access(func, data_in));
      if (out_valid && out_ready) begin
        got = {read_data, tx_valid, tx_byte, dropped};
        if (owed_results.size() == 0) begin
          failures++;
          $display("%0t: result beat with none expected: read_data=%h tx_valid=%b tx_byte=%h dropped=%b",
                   $time, got.rd, got.txv, got.txb, got.drop);
        end else begin
          want = owed_results.pop_front();
          if (got !== want) begin
            failures++;
            $display("%0t: mismatch: expected read_data=%h tx_valid=%b tx_byte=%h dropped=%b",
                     $time, want.rd, want.txv, want.txb, want.drop);
            $display("%0t:           actual read_data=%h tx_valid=%b tx_byte=%h dropped=%b",
                     $time, got.rd, got.txv, got.txb, got.drop);
          end
        end
      end
    end
    pending = owed_results.size();
  end

endmodule

/* tb/throttled_serial_receive_port_top_test.sv */
// Top of the throttled serial receive port testbench: clock, reset, stimulus, register
// phases and verdict. Depends on tsrp_pkg, the block and throttled_serial_receive_port_watch.
`timescale 1ns / 100ps

module throttled_serial_receive_port_top_test;
  import tsrp_pkg::*;

  localparam logic [2:0]           FN_SPARE_6     = 3'd6;
  localparam logic [2:0]           FN_SPARE_7     = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3    = 2'd3;
  localparam int                   HOLD_OFF_BEATS = 200;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic [2:0]            func;
  logic [7:0]            data_in;
  logic                  out_valid;
  logic                  out_ready;
  logic [7:0]            read_data;
  logic                  tx_valid;
  logic [7:0]            tx_byte;
  logic                  dropped;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    failures;
  int                    pending;

  int send_idle_pct;
  int stall_pct;
  int hold_requests;
  int holds_served;
  int hold_left;
  int items_sent;
  int throttle_now;

  throttled_serial_receive_port_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .data_in   (data_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .read_data (read_data),
    .tx_valid  (tx_valid),
    .tx_byte   (tx_byte),
    .dropped   (dropped),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  throttled_serial_receive_port_watch watch (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .data_in   (data_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .read_data (read_data),
    .tx_valid  (tx_valid),
    .tx_byte   (tx_byte),
    .dropped   (dropped),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .failures  (failures),
    .pending   (pending)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #400us;
    $display("Regression FAIL");
    $finish;
  end

  // The receiver stalls at random, and holds off for a long stretch when asked to.
  initial begin
    out_ready = 1'b0;
    holds_served = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = HOLD_OFF_BEATS;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_beat(input logic [2:0] fn, input logic [7:0] din);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    func <= fn;
    data_in <= din;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic set_throttling(input logic [LIMIT_W-1:0] limit, input logic [THR_W-1:0] ms);
    write_reg(REG_BURST_LIMIT, {8'($urandom), limit});
    write_reg(REG_THROTTLE_MS, ms);
    cfg_valid <= 1'b0;
    throttle_now = ms;
  endtask

  // Mostly fill and drain sequences with ticks to clear throttle waits, plus some noise.
  task automatic run_traffic(input int target);
    int kind;
    int len;
    int k;
    int t;
    while (items_sent < target) begin
      kind = $urandom_range(99);
      if (kind < 30) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(300, 240) : $urandom_range(24, 1);
        for (k = 0; k < len; k++) send_beat(FN_RX_BYTE, 8'($urandom));
      end else if (kind < 65) begin
        len = $urandom_range(30, 1);
        for (k = 0; k < len; k++) begin
          send_beat(($urandom_range(3) == 0) ? FN_STATUS_RD : FN_DATA_RD, 8'($urandom));
          if ($urandom_range(4) == 0) begin
            for (t = $urandom_range(throttle_now + 2, 1); t > 0; t--)
              send_beat(FN_TICK, 8'($urandom));
          end
        end
      end else if (kind < 80) begin
        for (k = $urandom_range(throttle_now + 2, 1); k > 0; k--)
          send_beat(FN_TICK, 8'($urandom));
      end else begin
        for (k = $urandom_range(8, 1); k > 0; k--)
          send_beat(3'($urandom_range(7)), 8'($urandom));
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    func = FN_CTRL_WR;
    data_in = 8'h00;
    cfg_valid = 1'b0;
    cfg_index = REG_BURST_LIMIT;
    cfg_data = '0;
    send_idle_pct = 6;
    stall_pct = 83;
    hold_requests = 0;
    items_sent = 0;
    throttle_now = THROTTLE_RST;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_beat(FN_DATA_RD, 8'h00);
    send_beat(FN_STATUS_RD, 8'hff);
    send_beat(FN_DATA_WR, 8'h00);
    send_beat(FN_DATA_WR, 8'hff);
    send_beat(FN_CTRL_WR, 8'h5a);
    send_beat(FN_TICK, 8'h00);
    send_beat(FN_SPARE_6, 8'hff);
    send_beat(FN_SPARE_7, 8'h81);
    send_beat(FN_RX_BYTE, 8'h00);
    send_beat(FN_RX_BYTE, 8'hff);
    send_beat(FN_RX_BYTE, 8'ha5);
    send_beat(FN_STATUS_RD, 8'h00);
    send_beat(FN_DATA_RD, 8'h00);
    send_beat(FN_DATA_RD, 8'h00);
    send_beat(FN_DATA_RD, 8'h00);
    send_beat(FN_DATA_RD, 8'h00);
    send_beat(FN_STATUS_RD, 8'h00);
    send_beat(FN_RX_BYTE, 8'h3c);
    send_beat(FN_DATA_RD, 8'h00);
    wait_quiet();

    set_throttling(8'd0, 16'd0);
    run_traffic(480);
    wait_quiet();

    send_idle_pct = 83;
    stall_pct <= 6;
    write_reg(REG_SPARE_2, 16'h5a5a);
    write_reg(REG_SPARE_3, 16'hffff);
    set_throttling(8'd255, 16'd3);
    run_traffic(960);
    wait_quiet();

    send_idle_pct = 0;
    stall_pct <= 0;
    set_throttling(8'($urandom_range(12, 1)), 16'($urandom_range(20, 1)));
    hold_requests <= hold_requests + 1;
    run_traffic(1440);
    wait_quiet();

    // Arm the longest throttle wait; it cannot run out before the end.
    set_throttling(8'd0, 16'hffff);
    send_beat(FN_RX_BYTE, 8'h11);
    send_beat(FN_RX_BYTE, 8'h22);
    send_beat(FN_RX_BYTE, 8'h33);
    send_beat(FN_RX_BYTE, 8'h44);
    send_beat(FN_DATA_RD, 8'h00);
    send_beat(FN_DATA_RD, 8'h00);
    send_beat(FN_DATA_RD, 8'h00);
    send_beat(FN_STATUS_RD, 8'h00);
    send_beat(FN_TICK, 8'h00);
    send_beat(FN_TICK, 8'h00);
    send_beat(FN_DATA_RD, 8'h00);
    send_beat(FN_STATUS_RD, 8'h00);
    wait_quiet();
    repeat (6) @(negedge clk);

    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
